@@ rtl/mtg_pkg.sv @@
// Shared definitions for the MT19937 generator: sizes, algorithm constants,
// the sequencer state type and the word-level helper functions.
// No dependencies.
package mtg_pkg;

    // Sizes
    localparam int WORD_W        = 32;
    localparam int MODE_W        = 2;
    localparam int STATE_WORDS   = 624;
    localparam int SHIFT_OFFSET  = 397;
    localparam int ADDR_W        = $clog2(STATE_WORDS + 2);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [MODE_W-1:0] mode_t;

    // Transaction modes
    localparam mode_t MODE_DRAW   = 2'd0;
    localparam mode_t MODE_RESEED = 2'd1;
    localparam mode_t MODE_LOAD   = 2'd2;

    // Index and address constants
    localparam addr_t LAST_ADDR    = addr_t'(STATE_WORDS - 1);
    localparam addr_t IDX_FULL     = addr_t'(STATE_WORDS);
    localparam addr_t IDX_UNSEEDED = addr_t'(STATE_WORDS + 1);
    localparam addr_t FAR_WRAP     = addr_t'(STATE_WORDS - SHIFT_OFFSET);
    localparam addr_t FAR_OFFSET   = addr_t'(SHIFT_OFFSET);

    // Algorithm constants
    localparam word_t MT_A         = 32'h9908b0df;
    localparam word_t MT_UPPER     = 32'h80000000;
    localparam word_t MT_LOWER     = 32'h7fffffff;
    localparam word_t MT_TB        = 32'h9d2c5680;
    localparam word_t MT_TC        = 32'hefc60000;
    localparam word_t HALF_MASK    = 32'hffff0000;
    localparam word_t DEFAULT_SEED = 32'd4357;
    localparam logic [16:0] LCG_MUL = 17'd69069;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_A,
        ST_SEED_B,
        ST_TW_PRIME,
        ST_TW_A,
        ST_TW_B,
        ST_DRAW_RD,
        ST_DRAW_OUT
    } mtg_state_t;

    // One step of the 69069 congruential sequence, modulo 2^32
    function automatic word_t lcg_step(input word_t s);
        logic [WORD_W+16:0] prod;
        prod = s * LCG_MUL;
        return prod[WORD_W-1:0] + word_t'(1);
    endfunction

    // Twist recurrence for one state word
    function automatic word_t mix_word(input word_t hi, input word_t lo, input word_t far);
        word_t y;
        word_t r;
        y = (hi & MT_UPPER) | (lo & MT_LOWER);
        r = far ^ (y >> 1);
        if (y[0])
        begin
            r = r ^ MT_A;
        end
        return r;
    endfunction

    // Output tempering
    function automatic word_t temper(input word_t y_in);
        word_t y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TB);
        y = y ^ ((y << 15) & MT_TC);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ rtl/mtg_req_if.sv @@
// Request channel of the MT19937 generator: valid/ready plus mode and load word.
// Depends on mtg_pkg.
interface mtg_req_if import mtg_pkg::*; ();
    logic  valid;
    logic  ready;
    mode_t mode;
    word_t load_word;

    modport source (output valid, output mode, output load_word, input ready);
    modport sink   (input valid, input mode, input load_word, output ready);
endinterface

@@ rtl/mtg_rsp_if.sv @@
// Result channel of the MT19937 generator: valid/ready plus the tempered word.
// Depends on mtg_pkg.
interface mtg_rsp_if import mtg_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

@@ rtl/mersenne_twister_generator.sv @@
// MT19937 generator top level: state memory, sequencer and output register.
// Depends on mtg_pkg, mtg_req_if and mtg_rsp_if.
//
// Usage:
//   req carries one transaction per item: mode 0 draws a number, mode 1
//   reseeds from the seed register, mode 2 writes load_word to the next state
//   word, mode 3 is ignored. Only a draw produces a transaction on rsp.
//   cfg_wr_en/cfg_wr_data write the seed register (reset value 4357); write
//   it only while the block is idle.
// Sequencing:
//   A draw from a live state is accepted, then tempered into the output
//   register. Every 624th draw first runs the twist pass, one word at a time
//   through the two-read, one-write state memory, then re-reads the word to
//   draw. A reseed is accepted, then takes two congruential steps per word
//   through one shared multiplier. The first draw after reset seeds with 4357
//   and twists first. Loads and ignored items are handled in the idle state.
// Reset and stall:
//   Reset leaves the state unseeded and the load pointer at 0; the memory is
//   not cleared. req.ready is high only between items. A result waits in the
//   output register while rsp stalls; a following draw holds until it is free.
module mersenne_twister_generator import mtg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mtg_req_if.sink      req,
    mtg_rsp_if.source    rsp,
    input  logic         cfg_wr_en,
    input  word_t        cfg_wr_data
);

    // State memory
    word_t mem [0:STATE_WORDS-1];

    // Control registers
    mtg_state_t state_reg, state_next;
    addr_t      read_index_reg, read_index_next;
    addr_t      load_ptr_reg, load_ptr_next;
    addr_t      cnt_reg, cnt_next;
    logic       draw_pend_reg, draw_pend_next;
    logic       rsp_valid_reg, rsp_valid_next;
    word_t      seed_value_reg;

    // Payload registers
    word_t       lcg_reg, lcg_next;
    logic [15:0] hi16_reg, hi16_next;
    word_t       hi_reg, hi_next;
    word_t       rsp_word_reg, rsp_word_next;
    word_t       rdata_a_reg, rdata_b_reg;

    // Memory port controls
    logic  mem_we;
    addr_t mem_waddr;
    word_t mem_wdata;
    logic  rd_en_a, rd_en_b;
    addr_t rd_addr_a, rd_addr_b;

    // Shared datapath results
    word_t lcg_out;
    addr_t far_addr;
    addr_t next_addr;

    assign lcg_out   = lcg_step(lcg_reg);
    assign far_addr  = (cnt_reg < FAR_WRAP) ? cnt_reg + FAR_OFFSET : cnt_reg - FAR_WRAP;
    assign next_addr = (cnt_reg == LAST_ADDR) ? '0 : cnt_reg + addr_t'(1);

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.random_word = rsp_word_reg;

    // Memory write and registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en_a)
        begin
            rdata_a_reg <= mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            rdata_b_reg <= mem[rd_addr_b];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            read_index_reg <= IDX_UNSEEDED;
            load_ptr_reg   <= '0;
            cnt_reg        <= '0;
            draw_pend_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            seed_value_reg <= DEFAULT_SEED;
        end
        else
        begin
            state_reg      <= state_next;
            read_index_reg <= read_index_next;
            load_ptr_reg   <= load_ptr_next;
            cnt_reg        <= cnt_next;
            draw_pend_reg  <= draw_pend_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                seed_value_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lcg_reg      <= lcg_next;
        hi16_reg     <= hi16_next;
        hi_reg       <= hi_next;
        rsp_word_reg <= rsp_word_next;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        read_index_next = read_index_reg;
        load_ptr_next   = load_ptr_reg;
        cnt_next        = cnt_reg;
        draw_pend_next  = draw_pend_reg;
        rsp_valid_next  = rsp_valid_reg;
        lcg_next        = lcg_reg;
        hi16_next       = hi16_reg;
        hi_next         = hi_reg;
        rsp_word_next   = rsp_word_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg;
        mem_wdata       = mix_word(hi_reg, rdata_a_reg, rdata_b_reg);
        rd_en_a         = 1'b0;
        rd_addr_a       = '0;
        rd_en_b         = 1'b0;
        rd_addr_b       = far_addr;

        // Output slot drains when taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // Read at the read index ahead of a possible draw
                rd_en_a   = 1'b1;
                rd_addr_a = (read_index_reg < IDX_FULL) ? read_index_reg : '0;
                if (req.valid)
                begin
                    priority case (req.mode)
                        MODE_DRAW:
                        begin
                            if (read_index_reg == IDX_UNSEEDED)
                            begin
                                lcg_next       = DEFAULT_SEED;
                                cnt_next       = '0;
                                draw_pend_next = 1'b1;
                                state_next     = ST_SEED_A;
                            end
                            else if (read_index_reg == IDX_FULL)
                            begin
                                state_next = ST_TW_PRIME;
                            end
                            else
                            begin
                                read_index_next = read_index_reg + addr_t'(1);
                                state_next      = ST_DRAW_OUT;
                            end
                        end
                        MODE_RESEED:
                        begin
                            lcg_next       = seed_value_reg;
                            cnt_next       = '0;
                            draw_pend_next = 1'b0;
                            load_ptr_next  = '0;
                            state_next     = ST_SEED_A;
                        end
                        MODE_LOAD:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = load_ptr_reg;
                            mem_wdata = req.load_word;
                            if (load_ptr_reg == LAST_ADDR)
                            begin
                                load_ptr_next   = '0;
                                read_index_next = IDX_FULL;
                            end
                            else
                            begin
                                load_ptr_next = load_ptr_reg + addr_t'(1);
                            end
                        end
                        default:
                        begin
                            // unused mode: no effect
                        end
                    endcase
                end
            end
            ST_SEED_A:
            begin
                // First step gives the upper half
                hi16_next  = lcg_reg[WORD_W-1:16];
                lcg_next   = lcg_out;
                state_next = ST_SEED_B;
            end
            ST_SEED_B:
            begin
                // Second step gives the lower half; store the word
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = {hi16_reg, lcg_reg[WORD_W-1:16]};
                lcg_next  = lcg_out;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next        = '0;
                    read_index_next = IDX_FULL;
                    state_next      = draw_pend_reg ? ST_TW_PRIME : ST_IDLE;
                    draw_pend_next  = 1'b0;
                end
                else
                begin
                    cnt_next   = cnt_reg + addr_t'(1);
                    state_next = ST_SEED_A;
                end
            end
            ST_TW_PRIME:
            begin
                // Fetch word 0 as the first upper-bit source
                rd_en_a    = 1'b1;
                rd_addr_a  = '0;
                cnt_next   = '0;
                state_next = ST_TW_A;
            end
            ST_TW_A:
            begin
                // Last fetched neighbor becomes this word's upper source
                hi_next    = rdata_a_reg;
                rd_en_a    = 1'b1;
                rd_addr_a  = next_addr;
                rd_en_b    = 1'b1;
                rd_addr_b  = far_addr;
                state_next = ST_TW_B;
            end
            ST_TW_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = mix_word(hi_reg, rdata_a_reg, rdata_b_reg);
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next        = '0;
                    read_index_next = '0;
                    state_next      = ST_DRAW_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + addr_t'(1);
                    state_next = ST_TW_A;
                end
            end
            ST_DRAW_RD:
            begin
                rd_en_a         = 1'b1;
                rd_addr_a       = read_index_reg;
                read_index_next = read_index_reg + addr_t'(1);
                state_next      = ST_DRAW_OUT;
            end
            ST_DRAW_OUT:
            begin
                // Temper into the output slot once it is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = temper(rdata_a_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        read_index_reg <= IDX_UNSEEDED)
        else $error("read index out of range");

    a_load_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_ptr_reg <= LAST_ADDR)
        else $error("load pointer out of range");

    a_twist_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TW_B && cnt_reg == LAST_ADDR)
        |=> (read_index_reg == '0 && state_reg == ST_DRAW_RD))
        else $error("twist pass did not rewind read index");

    a_draw_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW_OUT && !rsp_valid_reg) |=> (rsp.valid && state_reg == ST_IDLE))
        else $error("draw result not delivered to free output slot");

endmodule

@@ verif/tb_mersenne_twister_generator.sv @@
// Testbench for mersenne_twister_generator: directed table plus random traffic,
// every draw checked against an in-bench MT19937 model with random idling.
// Depends on mtg_pkg, mtg_req_if, mtg_rsp_if and the generator RTL.
module tb_mersenne_twister_generator;
    import mtg_pkg::*;

    localparam mode_t MODE_UNUSED   = 2'd3;
    localparam int    IDLE_MAX      = 14;
    localparam int    SETTLE_CYCLES = 1400;
    localparam int    QUIET_LIMIT   = 20000;

    typedef struct packed {
        mode_t mode;
        word_t ld_word;
    } req_row_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_wr_en;
    word_t cfg_wr_data;

    mtg_req_if req_if ();
    mtg_rsp_if rsp_if ();

    mersenne_twister_generator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Generator model state
    word_t       mt_words [STATE_WORDS];
    int unsigned rd_idx;
    int unsigned ld_ptr;
    word_t       seed_reg;
    word_t       expected_words [$];

    int error_count;
    int draws_sent;
    int reseeds_sent;
    int loads_sent;
    int ignored_sent;
    int twists_seen;
    int results_seen;
    int quiet_cycles;
    bit steady_flow;
    word_t last_seed;

    req_row_t directed_rows [0:24];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Fill the state from a seed: two congruential steps per word
    function automatic void fill_from_seed(input word_t s);
        word_t w;
        for (int i = 0; i < STATE_WORDS; i++)
        begin
            w = s & HALF_MASK;
            s = s * LCG_MUL + word_t'(1);
            w = w | ((s & HALF_MASK) >> 16);
            s = s * LCG_MUL + word_t'(1);
            mt_words[i] = w;
        end
        rd_idx = STATE_WORDS;
    endfunction

    // Regenerate all words in place
    function automatic void twist_words();
        int    nxt;
        int    far;
        word_t y;
        word_t r;
        for (int k = 0; k < STATE_WORDS; k++)
        begin
            nxt = (k + 1) % STATE_WORDS;
            far = (k + SHIFT_OFFSET) % STATE_WORDS;
            y = (mt_words[k] & MT_UPPER) | (mt_words[nxt] & MT_LOWER);
            r = mt_words[far] ^ (y >> 1);
            if (y[0])
            begin
                r = r ^ MT_A;
            end
            mt_words[k] = r;
        end
        rd_idx = 0;
        twists_seen++;
    endfunction

    function automatic word_t tempered_word(input word_t v);
        word_t y;
        y = v;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TB);
        y = y ^ ((y << 15) & MT_TC);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Apply one accepted request to the model, queue the expected word for a draw
    function automatic void advance_generator(input mode_t m, input word_t w);
        case (m)
            MODE_DRAW:
            begin
                if (rd_idx >= STATE_WORDS + 1)
                begin
                    fill_from_seed(DEFAULT_SEED);
                end
                if (rd_idx >= STATE_WORDS)
                begin
                    twist_words();
                end
                expected_words.push_back(tempered_word(mt_words[rd_idx]));
                rd_idx++;
                draws_sent++;
            end
            MODE_RESEED:
            begin
                fill_from_seed(seed_reg);
                ld_ptr = 0;
                reseeds_sent++;
            end
            MODE_LOAD:
            begin
                mt_words[ld_ptr] = w;
                ld_ptr++;
                if (ld_ptr >= STATE_WORDS)
                begin
                    ld_ptr = 0;
                    rd_idx = STATE_WORDS;
                end
                loads_sent++;
            end
            default:
            begin
                ignored_sent++;
            end
        endcase
    endfunction

    function automatic int pick_gap();
        if (steady_flow)
        begin
            return 0;
        end
        return $urandom_range(0, IDLE_MAX);
    endfunction

    // Drive one request transaction; starts and ends on a falling edge
    task automatic issue_request(input mode_t m, input word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid     = 1'b1;
        req_if.mode      = m;
        req_if.load_word = w;
        do
            @(posedge clk);
        while (!req_if.ready);
        advance_generator(m, w);
        @(negedge clk);
    endtask

    // Wait for all results, then let any reseed still running finish
    task automatic drain_and_settle();
        req_if.valid = 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_seed(input word_t v);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        seed_reg    = v;
        last_seed   = v;
    endtask

    // Random traffic: mostly draws, some loads, rare reseeds, a few unused modes
    task automatic run_random(input int n, input bit full_load);
        int    counted;
        int    pick;
        word_t w;
        if (full_load)
        begin
            for (int i = 0; i < STATE_WORDS; i++)
            begin
                if (i % 64 == 0)
                begin
                    steady_flow = ($urandom_range(0, 3) == 0);
                end
                w = $urandom();
                if ($urandom_range(0, 15) == 0)
                begin
                    w = $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
                end
                issue_request(MODE_LOAD, w);
            end
        end
        counted = 0;
        while (counted < n)
        begin
            if (counted % 64 == 0)
            begin
                steady_flow = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 199);
            w    = $urandom();
            if (pick == 0)
            begin
                issue_request(MODE_RESEED, w);
                counted++;
            end
            else if (pick <= 16)
            begin
                issue_request(MODE_LOAD, w);
                counted++;
            end
            else if (pick <= 26)
            begin
                issue_request(MODE_UNUSED, w);
            end
            else
            begin
                issue_request(MODE_DRAW, w);
                counted++;
            end
        end
    endtask

    // Result sink and checker
    initial
    begin
        int    gap;
        word_t exp_word;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_if.ready = 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
            results_seen++;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %08h",
                         $time, rsp_if.random_word);
                error_count++;
            end
            else
            begin
                exp_word = expected_words.pop_front();
                if (rsp_if.random_word !== exp_word)
                begin
                    $display("%0t: random_word mismatch: expected %08h, actual %08h",
                             $time, exp_word, rsp_if.random_word);
                    error_count++;
                end
            end
            @(negedge clk);
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles = 0;
        end
        else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, expected_words.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        req_if.valid     = 1'b0;
        req_if.mode      = MODE_DRAW;
        req_if.load_word = '0;
        seed_reg         = DEFAULT_SEED;
        last_seed        = DEFAULT_SEED;
        rd_idx           = STATE_WORDS + 1;
        ld_ptr           = 0;
        steady_flow      = 1'b0;
        error_count      = 0;
        draws_sent       = 0;
        reseeds_sent     = 0;
        loads_sent       = 0;
        ignored_sent     = 0;
        twists_seen      = 0;
        results_seen     = 0;
        quiet_cycles     = 0;
        for (int i = 0; i < STATE_WORDS; i++)
        begin
            mt_words[i] = '0;
        end

        // Partial load before seeding, unused mode, first draw seeds with the
        // default, loads read back through draws, reseeds incl. back to back
        directed_rows = '{
            {MODE_LOAD,   32'hffffffff},
            {MODE_LOAD,   32'h00000000},
            {MODE_UNUSED, 32'ha5a5a5a5},
            {MODE_DRAW,   32'h00000000},
            {MODE_DRAW,   32'hffffffff},
            {MODE_DRAW,   32'h00000000},
            {MODE_LOAD,   32'hffffffff},
            {MODE_LOAD,   32'h00000000},
            {MODE_LOAD,   32'h80000000},
            {MODE_LOAD,   32'h7fffffff},
            {MODE_UNUSED, 32'hffffffff},
            {MODE_DRAW,   32'h00000000},
            {MODE_DRAW,   32'h00000000},
            {MODE_DRAW,   32'h00000000},
            {MODE_DRAW,   32'h00000000},
            {MODE_RESEED, 32'hffffffff},
            {MODE_DRAW,   32'h00000000},
            {MODE_DRAW,   32'h00000000},
            {MODE_LOAD,   32'h00000001},
            {MODE_DRAW,   32'h00000000},
            {MODE_RESEED, 32'h00000000},
            {MODE_RESEED, 32'h00000000},
            {MODE_DRAW,   32'h00000000},
            {MODE_UNUSED, 32'h00000000},
            {MODE_DRAW,   32'h00000000}
        };

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            issue_request(directed_rows[i].mode, directed_rows[i].ld_word);
        end

        // Random phases, seed register changed only while idle
        drain_and_settle();
        write_seed(32'h00000000);
        run_random(350, 1'b0);

        drain_and_settle();
        write_seed(32'hffffffff);
        run_random(100, 1'b1);

        drain_and_settle();
        write_seed($urandom());
        run_random(600, 1'b0);

        drain_and_settle();

        $display("Covered %0d draws over %0d twist passes, %0d reseeds, %0d loads, %0d ignored",
                 draws_sent, twists_seen, reseeds_sent, loads_sent, ignored_sent);
        $display("Seed register went through 4357, 0, all ones and %08h; %0d results checked",
                 last_seed, results_seen);
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
